// File: hdl/lzrod_pkg.sv
// Shared types and constants for the LZSS relative-offset decoder.
// Used by lzrod_ram, lzrod_parse and lzss_relative_offset_decoder.
package lzrod_pkg;

  // Window geometry
  localparam int WIN_AW    = 12;
  localparam int WIN_DEPTH = 4096;
  localparam int MATCH_MAX = 18;
  localparam int MATCH_MIN = 3;
  localparam int LEN_W     = 5;

  // First window position written after a restart
  localparam logic [WIN_AW-1:0] WP_START = WIN_AW'(WIN_DEPTH - MATCH_MAX);

  // Parser phases, one-hot
  typedef enum logic [8:0] {
    PH_HDR0 = 9'b000000001,
    PH_HDR1 = 9'b000000010,
    PH_HDR2 = 9'b000000100,
    PH_HDR3 = 9'b000001000,
    PH_CTRL = 9'b000010000,
    PH_ITEM = 9'b000100000,
    PH_HIGH = 9'b001000000,
    PH_COPY = 9'b010000000,
    PH_DONE = 9'b100000000
  } phase_t;

  // Command from parser to copy engine, valid in the beat's cycle
  typedef struct packed {
    logic              restart;
    logic              lit;
    logic              ref_go;
    logic [7:0]        data;
    logic [WIN_AW-1:0] ref_dist;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // Status from copy engine back to parser
  typedef struct packed {
    logic item_end;
    logic done;
  } stat_t;

endpackage

// File: hdl/lzrod_ram.sv
// History window: 4096 x 8 synchronous RAM, one write and one read port,
// registered read data. Depends on lzrod_pkg.
module lzrod_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lzrod_pkg::WIN_AW-1:0] wa,
  input  logic [7:0]                  wd,
  input  logic                        re,
  input  logic [lzrod_pkg::WIN_AW-1:0] ra,
  output logic [7:0]                  q
);

  logic [7:0] mem [lzrod_pkg::WIN_DEPTH];

  // Read-before-write: a same-cycle read of the written entry sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q <= mem[ra];
    end
  end

endmodule

// File: hdl/lzrod_parse.sv
// Stream parser: length header, control bytes, literal/reference decode.
// Issues commands to the copy engine in the top level. Depends on lzrod_pkg.
module lzrod_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat,
  input  logic [7:0]          in_byte,
  input  logic                start,
  input  lzrod_pkg::stat_t    stat,
  output lzrod_pkg::cmd_t     cmd,
  output logic [31:0]         total_length
);

  lzrod_pkg::phase_t phase, phase_next, ph_eff;
  logic [31:0] total_next;
  logic [7:0]  ctrl, ctrl_next;
  logic [2:0]  idx, idx_next;
  logic [7:0]  ref_low, ref_low_next;

  // A restart beat is always taken as header byte zero
  assign ph_eff = start ? lzrod_pkg::PH_HDR0 : phase;

  // Command decode for the current beat
  always_comb begin
    cmd          = '0;
    cmd.restart  = beat && start;
    cmd.data     = in_byte;
    cmd.ref_dist = {in_byte[3:0], ref_low};
    cmd.len      = lzrod_pkg::LEN_W'(in_byte[7:4]) + lzrod_pkg::LEN_W'(lzrod_pkg::MATCH_MIN);
    if (beat) begin
      case (ph_eff)
        lzrod_pkg::PH_ITEM: cmd.lit    = !ctrl[idx];
        lzrod_pkg::PH_HIGH: cmd.ref_go = 1'b1;
        default:            ;
      endcase
    end
  end

  // Phase sequencing
  always_comb begin
    phase_next   = phase;
    total_next   = total_length;
    ctrl_next    = ctrl;
    idx_next     = idx;
    ref_low_next = ref_low;
    if (beat) begin
      if (start) begin
        total_next   = '0;
        ctrl_next    = '0;
        idx_next     = '0;
        ref_low_next = '0;
      end
      case (ph_eff)
        lzrod_pkg::PH_HDR0: begin
          total_next[7:0] = in_byte;
          phase_next      = lzrod_pkg::PH_HDR1;
        end
        lzrod_pkg::PH_HDR1: begin
          total_next[15:8] = in_byte;
          phase_next       = lzrod_pkg::PH_HDR2;
        end
        lzrod_pkg::PH_HDR2: begin
          total_next[23:16] = in_byte;
          phase_next        = lzrod_pkg::PH_HDR3;
        end
        lzrod_pkg::PH_HDR3: begin
          total_next[31:24] = in_byte;
          // zero length: nothing to produce
          phase_next = (total_next == 32'd0) ? lzrod_pkg::PH_DONE : lzrod_pkg::PH_CTRL;
        end
        lzrod_pkg::PH_CTRL: begin
          ctrl_next  = in_byte;
          idx_next   = '0;
          phase_next = lzrod_pkg::PH_ITEM;
        end
        lzrod_pkg::PH_ITEM: begin
          // literals finish through stat.item_end below
          if (ctrl[idx]) begin
            ref_low_next = in_byte;
            phase_next   = lzrod_pkg::PH_HIGH;
          end
        end
        lzrod_pkg::PH_HIGH: phase_next = lzrod_pkg::PH_COPY;
        default:            ;
      endcase
    end
    // item finished: next item of the group, new control byte, or done
    if (stat.item_end) begin
      if (stat.done) begin
        phase_next = lzrod_pkg::PH_DONE;
      end else begin
        idx_next   = idx + 3'd1;
        phase_next = (idx == 3'd7) ? lzrod_pkg::PH_CTRL : lzrod_pkg::PH_ITEM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lzrod_pkg::PH_HDR0;
      total_length <= '0;
      ctrl         <= '0;
      idx          <= '0;
      ref_low      <= '0;
    end else begin
      phase        <= phase_next;
      total_length <= total_next;
      ctrl         <= ctrl_next;
      idx          <= idx_next;
      ref_low      <= ref_low_next;
    end
  end

endmodule

// File: hdl/lzss_relative_offset_decoder.sv
// LZSS decoder top level: copy engine, fill tracking and output register.
// Instantiates lzrod_parse and lzrod_ram; depends on lzrod_pkg.
//
// Header bytes, control bytes, the low byte of a reference and literals are
// each consumed by one input beat; a literal's byte goes straight from that
// beat into the output register. The high byte of a reference starts a copy
// of len bytes, cut short at the declared length: the first window read is
// issued on that beat, then one byte per cycle with the output side ready,
// paced by the window RAM's registered read, each byte also written to the
// window. No input is taken while a copy runs or while a result waits at the
// output. The window needs no clearing pass: a fill count since the last
// restart marks which entries hold written data, and the rest read as zero.
module lzss_relative_offset_decoder (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] stream_start
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // last_of_run
  output logic       m_axis_tuser    // [0] stream_done
);

  localparam int AW = lzrod_pkg::WIN_AW;

  lzrod_pkg::cmd_t  cmd;
  lzrod_pkg::stat_t stat;
  logic [31:0] total_length;

  logic [AW-1:0] wp, wp_inc;
  logic [AW:0]   fill, fill_inc, fill_chk;
  logic [31:0]   produced, prod_inc;
  logic [AW-1:0] ref_dist;
  logic [lzrod_pkg::LEN_W-1:0] rem;
  logic          busy, rd_ok, fwd;
  logic [7:0]    last_byte;

  logic          emit_ok, beat, copy_emit, emit, emit_done, emit_last;
  logic [7:0]    emit_byte, ram_q;
  logic          rd_en, rd_ok_next;
  logic [AW-1:0] rd_addr, rd_off;

  // Handshake
  assign emit_ok       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !busy && emit_ok;
  assign beat          = s_axis_tvalid && s_axis_tready;
  assign copy_emit     = busy && emit_ok;
  assign emit          = copy_emit || cmd.lit;

  lzrod_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .in_byte      (s_axis_tdata),
    .start        (s_axis_tuser),
    .stat         (stat),
    .cmd          (cmd),
    .total_length (total_length)
  );

  // Byte selection: literal, forwarded last byte, window data or unwritten zero
  always_comb begin
    if (cmd.lit) begin
      emit_byte = cmd.data;
    end else if (fwd) begin
      emit_byte = last_byte;
    end else begin
      emit_byte = rd_ok ? ram_q : 8'h00;
    end
  end

  assign prod_inc      = produced + 32'd1;
  assign emit_done     = (prod_inc == total_length);
  assign emit_last     = cmd.lit || emit_done || (rem == lzrod_pkg::LEN_W'(1));
  assign stat.item_end = cmd.lit || (copy_emit && emit_last);
  assign stat.done     = emit_done;

  assign wp_inc   = wp + AW'(1);
  assign fill_inc = fill[AW] ? fill : fill + (AW+1)'(1);

  // Next window read and whether that entry was written since restart
  assign rd_en      = cmd.ref_go || (copy_emit && !emit_last);
  assign rd_addr    = cmd.ref_go ? (wp - cmd.ref_dist) : (wp_inc - ref_dist);
  assign fill_chk   = cmd.ref_go ? fill : fill_inc;
  assign rd_off     = rd_addr - lzrod_pkg::WP_START;
  assign rd_ok_next = fill_chk[AW] || (rd_off < fill_chk[AW-1:0]);

  lzrod_ram u_ram (
    .clk (clk),
    .we  (emit),
    .wa  (wp),
    .wd  (emit_byte),
    .re  (rd_en),
    .ra  (rd_addr),
    .q   (ram_q)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp            <= lzrod_pkg::WP_START;
      fill          <= '0;
      produced      <= '0;
      busy          <= 1'b0;
      rem           <= '0;
      rd_ok         <= 1'b0;
      fwd           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.restart) begin
        wp       <= lzrod_pkg::WP_START;
        fill     <= '0;
        produced <= '0;
      end
      if (emit) begin
        wp            <= wp_inc;
        fill          <= fill_inc;
        produced      <= prod_inc;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cmd.ref_go) begin
        busy  <= 1'b1;
        rem   <= cmd.len;
        rd_ok <= rd_ok_next;
        fwd   <= 1'b0;
      end else if (copy_emit) begin
        if (emit_last) begin
          busy <= 1'b0;
        end else begin
          rem   <= rem - lzrod_pkg::LEN_W'(1);
          rd_ok <= rd_ok_next;
          // distance one reads the entry written this cycle
          fwd   <= (ref_dist == AW'(1));
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.ref_go) begin
      ref_dist <= cmd.ref_dist;
    end
    if (emit) begin
      last_byte    <= emit_byte;
      m_axis_tdata <= emit_byte;
      m_axis_tlast <= emit_last;
      m_axis_tuser <= emit_done;
    end
  end

endmodule

// File: hdl/lzrod_chk.sv
// Port-level checker for lzss_relative_offset_decoder, bound to the top.
// Sees only top-level ports; no package dependency.
module lzrod_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // Output beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // No input taken while a result waits at the output
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted with output stalled");

  // Reaching the length always ends the run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("stream_done without tlast");

  // A restart beat is a header byte and produces nothing
  a_restart_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !m_axis_tvalid)
    else $error("output beat after restart");

endmodule

bind lzss_relative_offset_decoder lzrod_chk u_lzrod_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/lzss_relative_offset_decoder_tb.sv
// Self-checking testbench for lzss_relative_offset_decoder: an LZSS stream
// generator drives the input side; a byte-level predictor checks every output beat.
// Depends on lzrod_pkg and the decoder RTL.

// One expected output beat
typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic       done;
} out_beat_t;

// Tracks the decoder state per accepted input beat and holds the bytes it must emit
class lzss_byte_predictor;
  logic [7:0]                   window [lzrod_pkg::WIN_DEPTH];
  logic [lzrod_pkg::WIN_AW-1:0] wp;
  lzrod_pkg::phase_t            ph;
  logic [31:0]                  total_len;
  logic [31:0]                  produced;
  logic [7:0]                   ctrl;
  logic [2:0]                   bit_idx;
  logic [7:0]                   ref_low;
  out_beat_t                    expected_bytes[$];
  int                           err_count;

  function new();
    err_count = 0;
    restart();
  endfunction

  function void restart();
    foreach (window[i]) window[i] = 8'h00;
    wp        = lzrod_pkg::WP_START;
    ph        = lzrod_pkg::PH_HDR0;
    total_len = '0;
    produced  = '0;
    ctrl      = '0;
    bit_idx   = '0;
    ref_low   = '0;
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction

  // write one byte to the window and queue it; returns 1 at the declared length
  function bit emit(logic [7:0] v);
    out_beat_t e;
    window[wp] = v;
    wp         = wp + 1'b1;
    produced   = produced + 32'd1;
    e.data     = v;
    e.last     = 1'b0;
    e.done     = (produced == total_len);
    expected_bytes.push_back(e);
    return e.done;
  endfunction

  function void next_item(bit done);
    if (done) begin
      ph = lzrod_pkg::PH_DONE;
    end else begin
      bit_idx = bit_idx + 1'b1;
      ph = (bit_idx == 3'd0) ? lzrod_pkg::PH_CTRL : lzrod_pkg::PH_ITEM;
    end
  endfunction

  // accepted input beat; returns 0 when the decoder ignores it
  function bit absorb_byte(logic [7:0] b, logic st);
    int                           n_before;
    logic [lzrod_pkg::WIN_AW-1:0] ref_dist;
    int                           len;
    int                           i;
    bit                           done;
    bit                           used;
    out_beat_t                    tail;
    if (st) restart();
    n_before = expected_bytes.size();
    used = (ph != lzrod_pkg::PH_DONE);
    case (ph)
      lzrod_pkg::PH_HDR0: begin
        total_len[7:0] = b;
        ph = lzrod_pkg::PH_HDR1;
      end
      lzrod_pkg::PH_HDR1: begin
        total_len[15:8] = b;
        ph = lzrod_pkg::PH_HDR2;
      end
      lzrod_pkg::PH_HDR2: begin
        total_len[23:16] = b;
        ph = lzrod_pkg::PH_HDR3;
      end
      lzrod_pkg::PH_HDR3: begin
        total_len[31:24] = b;
        ph = (total_len == 32'd0) ? lzrod_pkg::PH_DONE : lzrod_pkg::PH_CTRL;
      end
      lzrod_pkg::PH_CTRL: begin
        ctrl    = b;
        bit_idx = '0;
        ph      = lzrod_pkg::PH_ITEM;
      end
      lzrod_pkg::PH_ITEM: begin
        if (!ctrl[bit_idx]) begin
          next_item(emit(b));
        end else begin
          ref_low = b;
          ph      = lzrod_pkg::PH_HIGH;
        end
      end
      lzrod_pkg::PH_HIGH: begin
        ref_dist = {b[3:0], ref_low};
        len      = int'(b[7:4]) + lzrod_pkg::MATCH_MIN;
        done     = 1'b0;
        // byte-wise copy so overlapping references repeat fresh bytes
        for (i = 0; i < len && !done; i++) begin
          done = emit(window[lzrod_pkg::WIN_AW'(wp - ref_dist)]);
        end
        next_item(done);
      end
      default: ;
    endcase
    // flag the final byte this beat caused
    if (expected_bytes.size() > n_before) begin
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
    return used;
  endfunction

  function void check_beat(logic [7:0] d, logic last, logic done);
    out_beat_t e;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected output beat data=%h last=%b done=%b", $time, d, last, done);
      err_count++;
      return;
    end
    e = expected_bytes.pop_front();
    if (d !== e.data) begin
      $display("%0t: out_byte expected %h actual %h", $time, e.data, d);
      err_count++;
    end
    if (last !== e.last) begin
      $display("%0t: last_of_run expected %b actual %b", $time, e.last, last);
      err_count++;
    end
    if (done !== e.done) begin
      $display("%0t: stream_done expected %b actual %b", $time, e.done, done);
      err_count++;
    end
  endfunction
endclass

module lzss_relative_offset_decoder_tb;

  logic       clk;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  lzss_byte_predictor sb = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int beats_used    = 0;

  lzss_relative_offset_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #2000000;
    $display("lzss_relative_offset_decoder_tb failed");
    $finish;
  end

  // output backpressure
  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // drive one input beat, at times after a random gap
  task automatic send_beat(input logic [7:0] b, input logic st);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (sb.absorb_byte(b, st)) beats_used++;
  endtask

  // hold the input side until every queued byte has come out
  task automatic drain_output();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // one compressed stream: header, then groups shaped by the decoder's current phase
  task automatic send_stream();
    logic [31:0] len;
    int          r;
    int          limit;
    int          sent;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 5) len = 32'd0;
    else if (r < 15) len = $urandom;
    else if (r < 25) len = $urandom_range(65, 400);
    else len = $urandom_range(1, 64);
    // some streams are cut off by the next restart
    limit = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 30) : $urandom_range(40, 120);
    send_beat(len[7:0], 1'b1);
    send_beat(len[15:8], 1'b0);
    send_beat(len[23:16], 1'b0);
    send_beat(len[31:24], 1'b0);
    sent = 0;
    while (sb.ph != lzrod_pkg::PH_DONE && sent < limit) begin
      b = 8'($urandom);
      if (sb.ph == lzrod_pkg::PH_ITEM && sb.ctrl[sb.bit_idx] && $urandom_range(0, 99) < 80) begin
        b = 8'($urandom_range(1, 24));        // short distance, low byte
      end else if (sb.ph == lzrod_pkg::PH_HIGH && $urandom_range(0, 99) < 80) begin
        b = {4'($urandom), 4'h0};             // random length, distance < 256
      end
      send_beat(b, 1'b0);
      sent++;
    end
    // trailing bytes after the end are ignored
    if (sb.ph == lzrod_pkg::PH_DONE && $urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 2)) send_beat(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int target;
    int p;
    int idle_tab  [4];
    int stall_tab [4];
    idle_tab  = '{0, 47, 0, 19};
    stall_tab = '{0, 0, 47, 19};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: length 27, literal extremes, longest overlapping copy,
    // group end, farthest distance cut short at the length, ignored tail,
    // restart into a zero-length stream
    send_beat(8'd27, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'hF0, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h7F, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h0F, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hC3, 1'b0);

    // random streams under each idling mix
    for (p = 0; p < 4; p++) begin
      drain_output();
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      target = beats_used + 100;
      while (beats_used < target) send_stream();
    end

    drain_output();
    repeat (40) @(posedge clk);
    if (sb.err_count == 0 && sb.pending() == 0) begin
      $display("lzss_relative_offset_decoder_tb passed");
    end else begin
      $display("lzss_relative_offset_decoder_tb failed");
    end
    $finish;
  end

endmodule
